// File: rtl/lruc_pkg.sv
`default_nettype none

package lruc_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned CAP_W  = 5;

   // operation codes carried in the request word
   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_SET = 1'b1;

   // read_value returned by a get that misses
   localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;

   // capacity after reset
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 5'd16;

   typedef struct packed {
      logic                     cmd;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DATA_W-1:0] read_value;
      logic                     evicted;
   } rsp_type;

   // recency table update command
   typedef struct packed {
      logic update;     // apply a touch this cycle
      logic age_all;    // age every valid entry, not only the younger ones
      logic set_valid;  // mark the touched slot valid (new insert)
   } age_ctl_type;

endpackage

`default_nettype wire

// File: rtl/lruc_ram.sv
`default_nettype none

module lruc_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/lruc_age.sv
`default_nettype none

// Per-entry valid bits and recency ranks (0 = most recent).
module lruc_age #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire lruc_pkg::age_ctl_type            ctl,
   input  wire logic [$clog2(MAX_ENTRIES)-1:0]   slot,
   input  wire logic [$clog2(MAX_ENTRIES)-1:0]   limit,
   input  wire logic [$clog2(MAX_ENTRIES)-1:0]   rd_idx,
   output logic                                  rd_valid,
   output logic      [$clog2(MAX_ENTRIES)-1:0]   rd_age
);

   localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
   localparam int unsigned AGE_W = IDX_W;

   logic             valid_ff [MAX_ENTRIES];
   logic [AGE_W-1:0] age_ff   [MAX_ENTRIES];

   // touch: zero the slot, age every valid entry younger than the limit (every valid entry under age_all)
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
         end
      end else if (ctl.update) begin
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == slot) begin
               age_ff[i] <= '0;
               if (ctl.set_valid) begin
                  valid_ff[i] <= 1'b1;
               end
            end else if (valid_ff[i] && (ctl.age_all || age_ff[i] < limit)) begin
               age_ff[i] <= age_ff[i] + AGE_W'(1);
            end
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_age   = age_ff[rd_idx];

endmodule

`default_nettype wire

// File: rtl/lru_key_value_cache_unit.sv
`default_nettype none

// Fully associative key/value cache with least-recently-used replacement.
// A request word (get or set, key, value) is taken on a clock edge where
// start is high and busy is low; busy then stays high until the response.
// One compare unit walks the key store one entry per cycle: the address
// side issues each entry, the compare side checks it after the registered
// RAM read, and the update state acts on the result before the strobe,
// and a new request may be started in the same cycle the strobe is shown.
// The response is on rsp_word for exactly one cycle, marked by rsp_valid;
// it cannot be held off, so the receiver must take it when it appears.
// A get hit returns the stored value, a get miss returns -1, a set returns
// 0 and flags evicted when it displaced the least recently used entry. The
// user must write capacity via csr_wr_en/csr_wr_data only while idle; the
// block does not enforce it. Zero acts as one and values above MAX_ENTRIES
// saturate. Valid bits and recency ranks reset at once, no clearing pass.
module lru_key_value_cache_unit #(
   parameter int unsigned MAX_ENTRIES = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire lruc_pkg::req_type             req_word,
   output logic                               rsp_valid,
   output lruc_pkg::rsp_type                  rsp_word,
   input  wire logic                          csr_wr_en,
   input  wire logic [lruc_pkg::CAP_W-1:0]    csr_wr_data
);

   localparam int unsigned IDX_W  = $clog2(MAX_ENTRIES);
   localparam int unsigned AGE_W  = IDX_W;
   localparam int unsigned CNT_W  = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned CMP_W  = (CNT_W > lruc_pkg::CAP_W) ? CNT_W : lruc_pkg::CAP_W;
   localparam int unsigned DATA_W = lruc_pkg::DATA_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ACT
   } state_type;

   state_type                    state_ff;
   lruc_pkg::req_type            req_ff;
   logic [lruc_pkg::CAP_W-1:0]   capacity_ff;
   logic [CNT_W-1:0]             entry_count_ff;

   // scan address side and compare side (trailing it by the registered RAM read)
   logic [IDX_W-1:0]             scan_idx_ff;
   logic                         issue_done_ff;
   logic [IDX_W-1:0]             cmp_idx_ff;
   logic                         cmp_vld_ff;

   // scan results
   logic                         found_ff;
   logic [IDX_W-1:0]             found_slot_ff;
   logic [AGE_W-1:0]             found_age_ff;
   logic [DATA_W-1:0]            found_value_ff;
   logic                         free_found_ff;
   logic [IDX_W-1:0]             free_slot_ff;
   logic                         lru_found_ff;
   logic [IDX_W-1:0]             lru_slot_ff;
   logic [AGE_W-1:0]             lru_age_ff;

   logic                         rsp_valid_ff;
   lruc_pkg::rsp_type            rsp_ff;

   // RAM and recency table connections
   logic [DATA_W-1:0]            key_rd_data;
   logic [DATA_W-1:0]            value_rd_data;
   logic                         key_we;
   logic                         value_we;
   logic [IDX_W-1:0]             tgt_slot;
   logic [AGE_W-1:0]             tgt_limit;
   lruc_pkg::age_ctl_type        age_ctl;
   logic                         rd_valid;
   logic [AGE_W-1:0]             rd_age;

   // update-cycle decision
   lruc_pkg::rsp_type            rsp_in;
   logic                         count_inc;
   logic [CMP_W-1:0]             cap_ext;
   logic [CMP_W-1:0]             eff_cap;
   logic                         full;
   logic                         accept;
   logic                         key_match;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign key_match = rd_valid && (key_rd_data == $unsigned(req_ff.key));

   // clamp capacity into 1 .. MAX_ENTRIES
   always_comb begin
      cap_ext = CMP_W'(capacity_ff);
      if (capacity_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         eff_cap = CMP_W'(MAX_ENTRIES);
      end else begin
         eff_cap = cap_ext;
      end
      full = (CMP_W'(entry_count_ff) >= eff_cap);
   end

   // pick the action once the scan is complete
   always_comb begin
      rsp_in.hit        = 1'b0;
      rsp_in.read_value = '0;
      rsp_in.evicted    = 1'b0;
      age_ctl           = '0;
      key_we            = 1'b0;
      value_we          = 1'b0;
      tgt_slot          = found_slot_ff;
      tgt_limit         = found_age_ff;
      count_inc         = 1'b0;
      if (state_ff == ST_ACT) begin
         if (req_ff.cmd == lruc_pkg::CMD_GET) begin
            if (found_ff) begin
               rsp_in.hit        = 1'b1;
               rsp_in.read_value = $signed(found_value_ff);
               age_ctl.update    = 1'b1;
            end else begin
               rsp_in.read_value = lruc_pkg::MISS_VALUE;
            end
         end else if (found_ff) begin
            // rewrite value of a present key
            rsp_in.hit     = 1'b1;
            value_we       = 1'b1;
            age_ctl.update = 1'b1;
         end else if (full) begin
            // overwrite the oldest valid entry
            tgt_slot  = lru_slot_ff;
            tgt_limit = lru_age_ff;
            if (lru_found_ff) begin
               rsp_in.evicted = 1'b1;
               key_we         = 1'b1;
               value_we       = 1'b1;
               age_ctl.update = 1'b1;
            end
         end else begin
            // fill the first free slot, age everything
            tgt_slot  = free_slot_ff;
            tgt_limit = '0;
            if (free_found_ff) begin
               key_we            = 1'b1;
               value_we          = 1'b1;
               age_ctl.update    = 1'b1;
               age_ctl.age_all   = 1'b1;
               age_ctl.set_valid = 1'b1;
               count_inc         = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         capacity_ff    <= lruc_pkg::CAPACITY_RESET;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         issue_done_ff  <= 1'b0;
         cmp_vld_ff     <= 1'b0;
         found_ff       <= 1'b0;
         free_found_ff  <= 1'b0;
         lru_found_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff        <= req_word;
                  scan_idx_ff   <= '0;
                  issue_done_ff <= 1'b0;
                  cmp_vld_ff    <= 1'b0;
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  lru_found_ff  <= 1'b0;
                  state_ff      <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               // address side: advance through the store
               cmp_vld_ff <= !issue_done_ff;
               cmp_idx_ff <= scan_idx_ff;
               if (!issue_done_ff) begin
                  if (scan_idx_ff == LAST_IDX) begin
                     issue_done_ff <= 1'b1;
                  end else begin
                     scan_idx_ff <= scan_idx_ff + IDX_W'(1);
                  end
               end
               // compare side: one entry per cycle
               if (cmp_vld_ff) begin
                  if (key_match && !found_ff) begin
                     found_ff       <= 1'b1;
                     found_slot_ff  <= cmp_idx_ff;
                     found_age_ff   <= rd_age;
                     found_value_ff <= value_rd_data;
                  end
                  if (!rd_valid && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_slot_ff  <= cmp_idx_ff;
                  end
                  if (rd_valid && (!lru_found_ff || rd_age > lru_age_ff)) begin
                     lru_found_ff <= 1'b1;
                     lru_slot_ff  <= cmp_idx_ff;
                     lru_age_ff   <= rd_age;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     state_ff <= ST_ACT;
                  end
               end
            end
            ST_ACT: begin
               rsp_valid_ff <= 1'b1;
               rsp_ff       <= rsp_in;
               if (count_inc) begin
                  entry_count_ff <= entry_count_ff + CNT_W'(1);
               end
               state_ff <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   lruc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (tgt_slot),
      .wr_data ($unsigned(req_ff.key)),
      .rd_addr (scan_idx_ff),
      .rd_data (key_rd_data)
   );

   lruc_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (value_we),
      .wr_addr (tgt_slot),
      .wr_data ($unsigned(req_ff.write_value)),
      .rd_addr (scan_idx_ff),
      .rd_data (value_rd_data)
   );

   lruc_age #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_age (
      .clock    (clock),
      .reset    (reset),
      .ctl      (age_ctl),
      .slot     (tgt_slot),
      .limit    (tgt_limit),
      .rd_idx   (cmp_idx_ff),
      .rd_valid (rd_valid),
      .rd_age   (rd_age)
   );

   // a response word only follows the update cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_ACT))
      else $error("response strobe without update cycle");

   // a set never both hits and evicts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.hit && rsp_ff.evicted))
      else $error("hit and evicted both set");

   // fill count never exceeds the store depth
   assert property (@(posedge clock) disable iff (reset)
      CMP_W'(entry_count_ff) <= CMP_W'(MAX_ENTRIES))
      else $error("entry count beyond depth");

   // an accepted word always starts a scan
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SCAN))
      else $error("accepted word did not start a scan");

endmodule

`default_nettype wire

// File: tb/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;

   localparam int SLOTS = 16;
   localparam int POOL_MAX = 24;
   localparam int PHASES = 8;

   // Recency-ordered key/value store mirror: it predicts each response word
   // from the request words seen so far and checks the words the block shows.
   class lru_scoreboard;
      logic signed [lruc_pkg::DATA_W-1:0] slot_key [SLOTS];
      logic signed [lruc_pkg::DATA_W-1:0] slot_val [SLOTS];
      bit                                 slot_live [SLOTS];
      int unsigned                        slot_rank [SLOTS];
      int unsigned                        live_count;
      logic [lruc_pkg::CAP_W-1:0]         capacity;
      lruc_pkg::rsp_type                  pending_rsp [$];
      int                                 errors;
      int                                 gets, sets, hits, evictions, settings;

      function new();
         foreach (slot_live[i]) begin
            slot_key[i] = '0;
            slot_val[i] = '0;
            slot_live[i] = 1'b0;
            slot_rank[i] = 0;
         end
         live_count = 0;
         capacity = lruc_pkg::CAPACITY_RESET;
      endfunction

      function void set_capacity(logic [lruc_pkg::CAP_W-1:0] value);
         capacity = value;
         settings++;
      endfunction

      // make slot s the most recent; live entries younger than limit age by one
      function void promote(int s, int unsigned limit);
         foreach (slot_live[i])
            if (slot_live[i] && i != s && slot_rank[i] < limit)
               slot_rank[i]++;
         slot_rank[s] = 0;
      endfunction

      function void note_request(lruc_pkg::req_type r);
         int                slot;
         int                victim;
         int                free_slot;
         int                usable;
         lruc_pkg::rsp_type exp;
         exp = '0;
         slot = -1;
         foreach (slot_live[i])
            if (slot < 0 && slot_live[i] && slot_key[i] == r.key)
               slot = i;
         usable = (capacity == 0) ? 1 : (capacity > SLOTS) ? SLOTS : int'(capacity);
         if (r.cmd == lruc_pkg::CMD_GET) begin
            gets++;
            if (slot >= 0) begin
               exp.hit = 1'b1;
               exp.read_value = slot_val[slot];
               promote(slot, slot_rank[slot]);
            end else begin
               exp.read_value = lruc_pkg::MISS_VALUE;
            end
         end else begin
            sets++;
            if (slot >= 0) begin
               exp.hit = 1'b1;
               slot_val[slot] = r.write_value;
               promote(slot, slot_rank[slot]);
            end else if (live_count >= usable || live_count >= SLOTS) begin
               victim = -1;
               foreach (slot_live[i])
                  if (slot_live[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                     victim = i;
               if (victim >= 0) begin
                  exp.evicted = 1'b1;
                  slot_key[victim] = r.key;
                  slot_val[victim] = r.write_value;
                  promote(victim, slot_rank[victim]);
               end
            end else begin
               free_slot = -1;
               foreach (slot_live[i])
                  if (free_slot < 0 && !slot_live[i])
                     free_slot = i;
               if (free_slot >= 0) begin
                  slot_key[free_slot] = r.key;
                  slot_val[free_slot] = r.write_value;
                  promote(free_slot, 32'hFFFF_FFFF);
                  slot_live[free_slot] = 1'b1;
                  live_count++;
               end
            end
         end
         if (exp.hit) hits++;
         if (exp.evicted) evictions++;
         pending_rsp.push_back(exp);
      endfunction

      task report(string msg);
         errors++;
         $display("ERROR at %0t ns: %s", $time, msg);
      endtask

      task check_response(lruc_pkg::rsp_type got);
         lruc_pkg::rsp_type exp;
         if (pending_rsp.size() == 0) begin
            report("response word with no request outstanding");
         end else begin
            exp = pending_rsp.pop_front();
            if (got.hit !== exp.hit)
               report($sformatf("hit %b, want %b", got.hit, exp.hit));
            if (got.read_value !== exp.read_value)
               report($sformatf("read_value %h, want %h", got.read_value, exp.read_value));
            if (got.evicted !== exp.evicted)
               report($sformatf("evicted %b, want %b", got.evicted, exp.evicted));
         end
      endtask
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   lruc_pkg::req_type          req_word = '0;
   logic                       rsp_valid;
   lruc_pkg::rsp_type          rsp_word;
   logic                       csr_wr_en = 1'b0;
   logic [lruc_pkg::CAP_W-1:0] csr_wr_data = '0;

   lru_key_value_cache_unit #(
      .MAX_ENTRIES(SLOTS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_word   (rsp_word),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   lru_scoreboard sb = new();

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sample both channels at the rising edge, before the block's own updates
   // land: a request word is taken when start is high and busy is low, and a
   // response word is taken whenever the strobe is up.
   always @(posedge clock) begin
      if (!reset && start && !busy)
         sb.note_request(req_word);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check_response(rsp_word);
   end

   function automatic lruc_pkg::req_type make_req(logic cmd,
                                                  logic [lruc_pkg::DATA_W-1:0] key,
                                                  logic [lruc_pkg::DATA_W-1:0] value);
      lruc_pkg::req_type r;
      r.cmd = cmd;
      r.key = key;
      r.write_value = value;
      return r;
   endfunction

   // Present a word and hold it until the block takes it. Start stays high on
   // return so that a following word can go out back to back.
   task automatic issue(input lruc_pkg::req_type r);
      req_word <= r;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Drop start and idle the sender for a burst of cycles.
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start and wait until every predicted response has come back.
   // The first edge lets the monitor record the word taken on the last one.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Write capacity; call only with the block idle.
   task automatic write_capacity(input logic [lruc_pkg::CAP_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_capacity(value);
      csr_wr_en <= 1'b0;
   endtask

   // Pick a value, now and then one of the extremes.
   function automatic logic [lruc_pkg::DATA_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h7FFF_FFFF;
         3:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      logic [lruc_pkg::DATA_W-1:0] pool [POOL_MAX];
      logic [lruc_pkg::CAP_W-1:0]  phase_cap [PHASES];
      int                          phase_items [PHASES];
      int                          pool_n;
      int                          usable;
      bit                          idling;
      logic [lruc_pkg::DATA_W-1:0] key;
      logic                        cmd;

      phase_cap   = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd7, 5'd0, 5'd16};
      phase_items = '{230, 230, 200, 230, 220, 230, 230, 260};
      phase_cap[6] = lruc_pkg::CAP_W'($urandom_range(0, 31));

      // hold reset, then release it for good
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words at capacity 2: miss on an empty cache, inserts until
      // full, a hit that reorders recency, eviction of the oldest entry, an
      // in-place update, and a get whose write_value must be ignored.
      write_capacity(5'd2);
      issue(make_req(lruc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000));
      issue(make_req(lruc_pkg::CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF));
      issue(make_req(lruc_pkg::CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000));
      issue(make_req(lruc_pkg::CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF));
      issue(make_req(lruc_pkg::CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      issue(make_req(lruc_pkg::CMD_GET, 32'h7FFF_FFFF, 32'h1234_5678));
      issue(make_req(lruc_pkg::CMD_SET, 32'h8000_0000, 32'h0000_0000));
      issue(make_req(lruc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
      issue(make_req(lruc_pkg::CMD_GET, 32'h8000_0000, 32'h0000_0000));
      issue(make_req(lruc_pkg::CMD_SET, 32'h0000_0000, 32'h5555_AAAA));
      issue(make_req(lruc_pkg::CMD_GET, 32'h0000_0000, 32'hAAAA_5555));
      issue(make_req(lruc_pkg::CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000));
      drain();

      // Capacity zero behaves as one, and it now sits below the entry count:
      // nothing is dropped, each new key replaces the oldest entry.
      write_capacity(5'd0);
      issue(make_req(lruc_pkg::CMD_SET, 32'h0000_0001, 32'h0000_0001));
      issue(make_req(lruc_pkg::CMD_GET, 32'h0000_0000, 32'h0000_0000));
      issue(make_req(lruc_pkg::CMD_SET, 32'h0000_0001, 32'h0000_0002));
      issue(make_req(lruc_pkg::CMD_GET, 32'h0000_0001, 32'h0000_0000));
      drain();

      // Capacity above the slot count saturates.
      write_capacity(5'd31);
      issue(make_req(lruc_pkg::CMD_SET, 32'h0000_0003, 32'hDEAD_BEEF));
      issue(make_req(lruc_pkg::CMD_SET, 32'h0000_0004, 32'h0BAD_F00D));
      issue(make_req(lruc_pkg::CMD_GET, 32'h0000_0003, 32'h0000_0000));
      drain();

      // Random phases: each runs at one capacity with a key pool a little
      // larger than the capacity, so hits, updates and evictions all recur.
      // A share of keys is drawn fresh to spread over the whole key space.
      for (int p = 0; p < PHASES; p++) begin
         write_capacity(phase_cap[p]);
         usable = (phase_cap[p] == 0) ? 1 : (phase_cap[p] > SLOTS) ? SLOTS
                                                                    : int'(phase_cap[p]);
         pool_n = usable + $urandom_range(1, 6);
         if (pool_n > POOL_MAX) pool_n = POOL_MAX;
         foreach (pool[i]) pool[i] = $urandom;
         if ($urandom_range(0, 1)) pool[0] = 32'h8000_0000;
         if ($urandom_range(0, 1)) pool[1] = 32'h7FFF_FFFF;
         idling = 1'b1;

         for (int n = 0; n < phase_items[p]; n++) begin
            // toggle between stretches with gaps and stretches without;
            // the final phase runs flat out
            if ($urandom_range(0, 39) == 0) idling = !idling;
            if (p != PHASES - 1 && idling && $urandom_range(0, 4) == 0)
               hold_off($urandom_range(1, 19));
            // now and then let the block run dry before the next word
            if (p != PHASES - 1 && (n == 100 || $urandom_range(0, 199) == 0))
               drain();

            key = ($urandom_range(0, 4) == 0) ? $urandom : pool[$urandom_range(0, pool_n - 1)];
            cmd = $urandom_range(0, 1) ? lruc_pkg::CMD_SET : lruc_pkg::CMD_GET;
            issue(make_req(cmd, key, pick_value()));
         end
         drain();
      end

      // let any stray response word show up before closing
      repeat (SLOTS + 4) @(posedge clock);
      if (sb.pending_rsp.size() != 0)
         sb.report($sformatf("%0d responses never arrived", sb.pending_rsp.size()));

      $display("Covered %0d gets and %0d sets across %0d capacity writes,",
               sb.gets, sb.sets, sb.settings);
      $display("with %0d hits and %0d evictions of the oldest entry.",
               sb.hits, sb.evictions);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin : watchdog
      #(10_000_000);
      $display("simulation failed");
      $finish;
   end

endmodule
